### hw/rtl/stt_pkg.sv
// Shared types, character codes and classification helpers for the source text tokenizer.
package stt_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned PtrW     = $clog2(OutDepth);
  localparam int unsigned CntW     = $clog2(OutDepth + 1);

  typedef struct packed {
    logic [7:0] out_char;
    logic       starts_token;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_single_sep(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (c)
      8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h28, 8'h29, 8'h26, 8'h7C,
      8'h5B, 8'h5D, 8'h2C, 8'h7B, 8'h7D, ChNl, ChEq: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_op_first(input logic [7:0] c);
    return (c == ChLt) || (c == ChGt) || (c == ChEq) || (c == ChBang);
  endfunction

endpackage

### hw/rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer.
// The tokenizer takes one text byte per cycle and passes token bytes on, one
// result per cycle, marking the first byte of each token. Each transaction is
// classified in the cycle it is accepted and its results enter a four-entry
// result queue, from which the output reads them in order.
// Input stall rises only when the queue holds more than two results, which
// happens when the output side stalls or when end-of-text transactions with two
// results come faster than the output can take the extra result; with a
// free-flowing output the sustained rate is one byte per cycle.
module source_text_tokenizer import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       starts_token_o,
  output logic       last_o
);

  logic  accept;
  logic  full;
  push_t push;
  res_t  res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stt_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push)
  );

  stt_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign out_char_o     = res.out_char;
  assign starts_token_o = res.starts_token;
  assign last_o         = res.last;

endmodule

### hw/rtl/stt_core.sv
// Token classification logic and tokenizer state flags.
module stt_core import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output push_t      push_o
);

  logic in_word_q, in_word_d;
  logic pending_q, pending_d;
  logic in_string_q, in_string_d;
  logic seen_q, seen_d;
  push_t push;

  always_comb begin
    in_word_d   = in_word_q;
    pending_d   = pending_q;
    in_string_d = in_string_q;
    seen_d      = seen_q;
    push        = '0;
    push.r0.out_char = text_byte_i;
    push.r0.last     = 1'b1;
    if (end_of_text_i) begin
      in_word_d   = 1'b0;
      pending_d   = 1'b0;
      in_string_d = 1'b0;
      seen_d      = 1'b0;
      if (in_string_q) begin
        push.r0 = '{out_char: ChQuote, starts_token: 1'b0, last: !seen_q};
        push.r1 = '{out_char: ChNl, starts_token: 1'b1, last: 1'b1};
        push.num = seen_q ? 2'd2 : 2'd1;
      end else if (seen_q) begin
        push.r0 = '{out_char: ChNl, starts_token: 1'b1, last: 1'b1};
        push.num = 2'd1;
      end
    end else begin
      push.num = 2'd1;
      seen_d   = 1'b1;
      priority if (in_string_q) begin
        if (text_byte_i == ChQuote) begin
          in_string_d = 1'b0;
        end
      end else if (text_byte_i == ChSpace) begin
        push.num  = 2'd0;
        seen_d    = seen_q;
        in_word_d = 1'b0;
        pending_d = 1'b0;
      end else if (text_byte_i == ChQuote) begin
        push.r0.starts_token = 1'b1;
        in_string_d = 1'b1;
        in_word_d   = 1'b0;
        pending_d   = 1'b0;
      end else if (pending_q && (text_byte_i == ChEq)) begin
        pending_d = 1'b0;
      end else if (is_op_first(text_byte_i)) begin
        push.r0.starts_token = 1'b1;
        pending_d = 1'b1;
        in_word_d = 1'b0;
      end else if (is_single_sep(text_byte_i)) begin
        push.r0.starts_token = 1'b1;
        in_word_d = 1'b0;
        pending_d = 1'b0;
      end else if (!in_word_q) begin
        push.r0.starts_token = 1'b1;
        in_word_d = 1'b1;
        pending_d = 1'b0;
      end else begin
        pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q   <= 1'b0;
      pending_q   <= 1'b0;
      in_string_q <= 1'b0;
      seen_q      <= 1'b0;
    end else if (accept_i) begin
      in_word_q   <= in_word_d;
      pending_q   <= pending_d;
      in_string_q <= in_string_d;
      seen_q      <= seen_d;
    end
  end

  always_comb begin
    push_o = push;
    if (!accept_i) begin
      push_o.num = 2'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_text_i |=> !in_word_q && !pending_q && !in_string_q && !seen_q)
    else $error("state not cleared after end of text");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({in_word_q, pending_q, in_string_q}) <= 1)
    else $error("word, operator and string flags overlap");
  a_string_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_string_q |-> seen_q)
    else $error("open string without any token seen");
`endif

endmodule

### hw/rtl/stt_out_fifo.sv
// Small result queue that takes up to two results per cycle and delivers one.
module stt_out_fifo import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_res_o
);

  res_t            mem_q [OutDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_next;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign full_o      = (cnt_q > CntW'(OutDepth - 2));
  assign wr_next     = wr_q + PtrW'(1);
  assign cnt_d       = cnt_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.num);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutDepth))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> !full_o)
    else $error("push while queue lacks room");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == CntW'(OutDepth)) || (PtrW'(wr_q - rd_q) == PtrW'(cnt_q)))
    else $error("queue pointers disagree with count");
`endif

endmodule
